// ----- hw/rtl/cbez_pkg.sv -----
// ============================================================================
// cbez_pkg: cubic Bezier evaluator shared definitions
// Fixed-point widths, register map and the types passed between pipeline units.
// ============================================================================
package cbez_pkg;

    // Number formats
    localparam int T_FRAC_BITS = 16;
    localparam int COORD_WIDTH = 32;

    // Parameter t and the blending weights (largest weight is 3.0)
    localparam int T_W = T_FRAC_BITS + 1;
    localparam int W_W = T_FRAC_BITS + 2;

    // Control points, their differences and magnitudes (|v| <= 2^(COORD_WIDTH+1))
    localparam int CP_W  = COORD_WIDTH + 3;
    localparam int MAG_W = COORD_WIDTH + 2;

    // Weighted terms and sums
    localparam int PROD_W = MAG_W + W_W;
    localparam int TMAG_W = PROD_W - T_FRAC_BITS;
    localparam int TERM_W = TMAG_W + 1;
    localparam int SUM_W  = TERM_W + 2;

    // Term layout: four position terms, then three tangent terms
    localparam int NUM_TERMS = 7;
    localparam int NUM_POS   = 4;

    // Register map
    localparam int NUM_REGS = 8;
    localparam int IDX_W    = $clog2(NUM_REGS);
    localparam int ADDR_W   = IDX_W + 2;

    localparam logic [IDX_W-1:0] REG_START_X    = 3'd0;
    localparam logic [IDX_W-1:0] REG_START_Y    = 3'd1;
    localparam logic [IDX_W-1:0] REG_START_HDX  = 3'd2;
    localparam logic [IDX_W-1:0] REG_START_HDY  = 3'd3;
    localparam logic [IDX_W-1:0] REG_END_X      = 3'd4;
    localparam logic [IDX_W-1:0] REG_END_Y      = 3'd5;
    localparam logic [IDX_W-1:0] REG_END_HDX    = 3'd6;
    localparam logic [IDX_W-1:0] REG_END_HDY    = 3'd7;

    typedef logic [W_W-1:0] weight_t;
    typedef weight_t [NUM_TERMS-1:0] weight_vec_t;

    // Sign and magnitude of one operand (control point or difference)
    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
    } operand_t;

    typedef operand_t [NUM_TERMS-1:0] axis_ops_t;

    typedef logic signed [TERM_W-1:0] term_t;
    typedef term_t [NUM_TERMS-1:0] term_vec_t;

endpackage

// ----- hw/rtl/cbez_cfg.sv -----
// ============================================================================
// cbez_cfg: configuration registers and control point preparation
// APB register file; derives control points, their differences and the
// sign/magnitude operands for both axes through two register levels.
// ============================================================================
module cbez_cfg
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cbez_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output cbez_pkg::axis_ops_t           ops_x,
    output cbez_pkg::axis_ops_t           ops_y
);

    localparam int EXT_W = cbez_pkg::CP_W - cbez_pkg::COORD_WIDTH;

    logic [cbez_pkg::COORD_WIDTH-1:0] cfg_reg [cbez_pkg::NUM_REGS];
    logic [cbez_pkg::IDX_W-1:0]       idx;
    logic                             wr_en;

    assign idx    = paddr[cbez_pkg::ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = cfg_reg[idx];

    // Register file write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < cbez_pkg::NUM_REGS; i++)
            begin
                cfg_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            cfg_reg[idx] <= pwdata[cbez_pkg::COORD_WIDTH-1:0];
        end
    end

    cbez_pkg::axis_ops_t ops_arr [2];

    for (genvar ax = 0; ax < 2; ax++)
    begin : g_axis
        localparam logic [cbez_pkg::IDX_W-1:0] I_P0 =
            (ax == 0) ? cbez_pkg::REG_START_X : cbez_pkg::REG_START_Y;
        localparam logic [cbez_pkg::IDX_W-1:0] I_H0 =
            (ax == 0) ? cbez_pkg::REG_START_HDX : cbez_pkg::REG_START_HDY;
        localparam logic [cbez_pkg::IDX_W-1:0] I_P3 =
            (ax == 0) ? cbez_pkg::REG_END_X : cbez_pkg::REG_END_Y;
        localparam logic [cbez_pkg::IDX_W-1:0] I_H1 =
            (ax == 0) ? cbez_pkg::REG_END_HDX : cbez_pkg::REG_END_HDY;

        logic signed [cbez_pkg::CP_W-1:0] p0_ext, h0_ext, p3_ext, h1_ext;
        logic signed [cbez_pkg::CP_W-1:0] p0_reg, p1_reg, p2_reg, p3_reg;
        logic signed [cbez_pkg::CP_W-1:0] p0_next, p1_next, p2_next, p3_next;
        logic signed [cbez_pkg::CP_W-1:0] val [cbez_pkg::NUM_TERMS];
        cbez_pkg::axis_ops_t              ops_reg, ops_next;

        assign p0_ext = $signed({{EXT_W{cfg_reg[I_P0][cbez_pkg::COORD_WIDTH-1]}},
                                 cfg_reg[I_P0]});
        assign h0_ext = $signed({{EXT_W{cfg_reg[I_H0][cbez_pkg::COORD_WIDTH-1]}},
                                 cfg_reg[I_H0]});
        assign p3_ext = $signed({{EXT_W{cfg_reg[I_P3][cbez_pkg::COORD_WIDTH-1]}},
                                 cfg_reg[I_P3]});
        assign h1_ext = $signed({{EXT_W{cfg_reg[I_H1][cbez_pkg::COORD_WIDTH-1]}},
                                 cfg_reg[I_H1]});

        // Level 1: control points
        assign p0_next = p0_ext;
        assign p1_next = p0_ext + h0_ext;
        assign p3_next = p3_ext;
        assign p2_next = p3_ext + h1_ext;

        // Level 2: points and differences as sign/magnitude
        always_comb
        begin
            val[0] = p0_reg;
            val[1] = p1_reg;
            val[2] = p2_reg;
            val[3] = p3_reg;
            val[4] = p1_reg - p0_reg;
            val[5] = p2_reg - p1_reg;
            val[6] = p3_reg - p2_reg;
            for (int k = 0; k < cbez_pkg::NUM_TERMS; k++)
            begin
                ops_next[k].neg = val[k][cbez_pkg::CP_W-1];
                ops_next[k].mag = val[k][cbez_pkg::CP_W-1]
                                ? cbez_pkg::MAG_W'(-val[k])
                                : cbez_pkg::MAG_W'(val[k]);
            end
        end

        always_ff @(posedge clk)
        begin
            p0_reg  <= p0_next;
            p1_reg  <= p1_next;
            p2_reg  <= p2_next;
            p3_reg  <= p3_next;
            ops_reg <= ops_next;
        end

        assign ops_arr[ax] = ops_reg;
    end

    assign ops_x = ops_arr[0];
    assign ops_y = ops_arr[1];

endmodule

// ----- hw/rtl/cbez_weights.sv -----
// ============================================================================
// cbez_weights: Bernstein weight pipeline
// Three stages: clamp t and form s = 1 - t; square and cross products;
// cubes, scaled blend weights and derivative weights.
// ============================================================================
module cbez_weights
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_vld,
    input  logic [cbez_pkg::T_W-1:0]     in_t,
    output logic                         out_vld,
    output cbez_pkg::weight_vec_t        out_w
);

    localparam int T_W = cbez_pkg::T_W;
    localparam int W_W = cbez_pkg::W_W;
    localparam logic [T_W-1:0] ONE_T = T_W'(2 ** cbez_pkg::T_FRAC_BITS);
    localparam logic [2*T_W-1:0] HALF_T = (2*T_W)'(2 ** (cbez_pkg::T_FRAC_BITS - 1));

    // Rounded Q1.F product, half up
    function automatic logic [T_W-1:0] rmul(logic [T_W-1:0] a, logic [T_W-1:0] b);
        logic [2*T_W-1:0] p;
        p = (2*T_W)'(a) * (2*T_W)'(b) + HALF_T;
        return p[cbez_pkg::T_FRAC_BITS +: T_W];
    endfunction

    function automatic logic [W_W-1:0] x3(logic [T_W-1:0] a);
        return (W_W'(a) << 1) + W_W'(a);
    endfunction

    // Stage 0: clamp and complement
    logic            v0_reg, v0_next;
    logic [T_W-1:0]  t0_reg, t0_next, s0_reg, s0_next;

    always_comb
    begin
        v0_next = in_vld;
        t0_next = (in_t > ONE_T) ? ONE_T : in_t;
        s0_next = ONE_T - t0_next;
    end

    // Stage 1: s^2, t^2, s*t
    logic            v1_reg, v1_next;
    logic [T_W-1:0]  t1_reg, s1_reg, s2_reg, t2_reg, st_reg;
    logic [T_W-1:0]  s2_next, t2_next, st_next;

    assign v1_next = v0_reg;
    assign s2_next = rmul(s0_reg, s0_reg);
    assign t2_next = rmul(t0_reg, t0_reg);
    assign st_next = rmul(s0_reg, t0_reg);

    // Stage 2: final weights
    logic                  v2_reg, v2_next;
    cbez_pkg::weight_vec_t w_reg, w_next;

    always_comb
    begin
        v2_next   = v1_reg;
        w_next[0] = W_W'(rmul(s2_reg, s1_reg));              // s^3
        w_next[1] = x3(rmul(s2_reg, t1_reg));                // 3 s^2 t
        w_next[2] = x3(rmul(s1_reg, t2_reg));                // 3 s t^2
        w_next[3] = W_W'(rmul(t2_reg, t1_reg));              // t^3
        w_next[4] = x3(s2_reg);                              // 3 s^2
        w_next[5] = (W_W'(st_reg) << 2) + (W_W'(st_reg) << 1); // 6 s t
        w_next[6] = x3(t2_reg);                              // 3 t^2
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= v0_next;
            v1_reg <= v1_next;
            v2_reg <= v2_next;
        end
    end

    // Data registers
    always_ff @(posedge clk)
    begin
        t0_reg <= t0_next;
        s0_reg <= s0_next;
        t1_reg <= t0_reg;
        s1_reg <= s0_reg;
        s2_reg <= s2_next;
        t2_reg <= t2_next;
        st_reg <= st_next;
        w_reg  <= w_next;
    end

    assign out_vld = v2_reg;
    assign out_w   = w_reg;

endmodule

// ----- hw/rtl/cbez_terms.sv -----
// ============================================================================
// cbez_terms: weighted term multipliers
// One stage of fourteen magnitude-by-weight products, each rounded half up in
// magnitude and given back its sign.
// ============================================================================
module cbez_terms
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_vld,
    input  cbez_pkg::weight_vec_t        in_w,
    input  cbez_pkg::axis_ops_t          ops_x,
    input  cbez_pkg::axis_ops_t          ops_y,
    output logic                         out_vld,
    output cbez_pkg::term_vec_t          terms_x,
    output cbez_pkg::term_vec_t          terms_y
);

    localparam int PROD_W = cbez_pkg::PROD_W;
    localparam logic [PROD_W-1:0] HALF_P = PROD_W'(2 ** (cbez_pkg::T_FRAC_BITS - 1));

    // Symmetric rounding of v * w to the coordinate format
    function automatic cbez_pkg::term_t wterm(cbez_pkg::operand_t op,
                                              cbez_pkg::weight_t w);
        logic [PROD_W-1:0]               p;
        logic signed [cbez_pkg::TERM_W-1:0] m;
        p = PROD_W'(op.mag) * PROD_W'(w) + HALF_P;
        m = $signed({1'b0, p[cbez_pkg::T_FRAC_BITS +: cbez_pkg::TMAG_W]});
        return op.neg ? -m : m;
    endfunction

    logic                vld_reg;
    cbez_pkg::term_vec_t tx_reg, tx_next, ty_reg, ty_next;

    always_comb
    begin
        for (int k = 0; k < cbez_pkg::NUM_TERMS; k++)
        begin
            tx_next[k] = wterm(ops_x[k], in_w[k]);
            ty_next[k] = wterm(ops_y[k], in_w[k]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        tx_reg <= tx_next;
        ty_reg <= ty_next;
    end

    assign out_vld = vld_reg;
    assign terms_x = tx_reg;
    assign terms_y = ty_reg;

endmodule

// ----- hw/rtl/cbez_sum.sv -----
// ============================================================================
// cbez_sum: term accumulation and saturation
// Stage one adds the position and tangent terms exactly; stage two clamps
// each sum to the coordinate range and drives the result registers.
// ============================================================================
module cbez_sum
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_vld,
    input  cbez_pkg::term_vec_t                  terms_x,
    input  cbez_pkg::term_vec_t                  terms_y,
    output logic                                 done,
    output logic [cbez_pkg::COORD_WIDTH-1:0]     pos_x,
    output logic [cbez_pkg::COORD_WIDTH-1:0]     pos_y,
    output logic [cbez_pkg::COORD_WIDTH-1:0]     tan_x,
    output logic [cbez_pkg::COORD_WIDTH-1:0]     tan_y,
    output logic                                 clipped
);

    localparam int SUM_W = cbez_pkg::SUM_W;
    localparam int CW    = cbez_pkg::COORD_WIDTH;
    localparam logic [CW-1:0] MAX_C = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] MIN_C = {1'b1, {(CW-1){1'b0}}};

    typedef logic signed [SUM_W-1:0] sum_t;

    function automatic sum_t add_terms(cbez_pkg::term_vec_t tv, int first, int cnt);
        sum_t acc;
        acc = '0;
        for (int k = 0; k < cnt; k++)
        begin
            acc = acc + SUM_W'($signed(tv[first + k]));
        end
        return acc;
    endfunction

    // Stage A: exact sums (index 0/1 position x/y, 2/3 tangent x/y)
    logic vs_reg;
    sum_t sum_reg [4];
    sum_t sum_next [4];

    always_comb
    begin
        sum_next[0] = add_terms(terms_x, 0, cbez_pkg::NUM_POS);
        sum_next[1] = add_terms(terms_y, 0, cbez_pkg::NUM_POS);
        sum_next[2] = add_terms(terms_x, cbez_pkg::NUM_POS,
                                cbez_pkg::NUM_TERMS - cbez_pkg::NUM_POS);
        sum_next[3] = add_terms(terms_y, cbez_pkg::NUM_POS,
                                cbez_pkg::NUM_TERMS - cbez_pkg::NUM_POS);
    end

    // Stage B: saturation
    logic          done_reg, clip_next, clip_reg;
    logic [CW-1:0] res_next [4];
    logic [CW-1:0] res_reg [4];
    logic [3:0]    ovf;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            // upper bits must all match the sign to fit
            if (!sum_reg[i][SUM_W-1] && (|sum_reg[i][SUM_W-2:CW-1]))
            begin
                res_next[i] = MAX_C;
                ovf[i]      = 1'b1;
            end
            else if (sum_reg[i][SUM_W-1] && !(&sum_reg[i][SUM_W-2:CW-1]))
            begin
                res_next[i] = MIN_C;
                ovf[i]      = 1'b1;
            end
            else
            begin
                res_next[i] = sum_reg[i][CW-1:0];
                ovf[i]      = 1'b0;
            end
        end
        clip_next = |ovf;
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vs_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            vs_reg   <= in_vld;
            done_reg <= vs_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            sum_reg[i] <= sum_next[i];
            res_reg[i] <= res_next[i];
        end
        clip_reg <= clip_next;
    end

    assign done    = done_reg;
    assign pos_x   = res_reg[0];
    assign pos_y   = res_reg[1];
    assign tan_x   = res_reg[2];
    assign tan_y   = res_reg[3];
    assign clipped = clip_reg;

endmodule

// ----- hw/rtl/cubic_bezier_point_and_tangent_core.sv -----
// ============================================================================
// cubic_bezier_point_and_tangent_core: 2D cubic Bezier point and tangent
// Evaluates position and derivative of a configured curve for each t.
// ============================================================================
// Usage:
//   Program the eight curve registers (start point, start handle, end point,
//   end handle; signed Q16.16) through the APB port at byte address 4*index
//   while no evaluation is in flight. pready is always high.
//   Issue a t (Q1.16, 65536 = 1.0, larger values clamp to 1.0) by raising
//   start; a transfer takes place at every rising edge with start high and
//   busy low. busy stays low: one t is taken every cycle.
//   Each result (pos_x, pos_y, tan_x, tan_y, clipped) is shown for exactly
//   one cycle with done high, in issue order. The result of each accepted t
//   passes through three weight stages, one multiplier stage, one adder
//   stage and one saturation stage.
//   Throughput is one evaluation per cycle; the results cannot be held off,
//   so nothing ever backs up.
//   Reset clears the registers to zero and empties the pipeline; no clearing
//   pass is needed.
// ============================================================================
module cubic_bezier_point_and_tangent_core
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [cbez_pkg::ADDR_W-1:0]          paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready,
    // command
    input  logic                                 start,
    output logic                                 busy,
    input  logic [cbez_pkg::T_W-1:0]             param_t,
    // result
    output logic                                 done,
    output logic [cbez_pkg::COORD_WIDTH-1:0]     pos_x,
    output logic [cbez_pkg::COORD_WIDTH-1:0]     pos_y,
    output logic [cbez_pkg::COORD_WIDTH-1:0]     tan_x,
    output logic [cbez_pkg::COORD_WIDTH-1:0]     tan_y,
    output logic                                 clipped
);

    cbez_pkg::axis_ops_t   ops_x, ops_y;
    cbez_pkg::weight_vec_t w_vec;
    cbez_pkg::term_vec_t   terms_x, terms_y;
    logic                  in_vld, w_vld, t_vld;

    // Fully pipelined: never busy
    assign busy   = 1'b0;
    assign in_vld = start && !busy;

    cbez_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .ops_x   (ops_x),
        .ops_y   (ops_y)
    );

    cbez_weights u_weights
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (in_vld),
        .in_t    (param_t),
        .out_vld (w_vld),
        .out_w   (w_vec)
    );

    cbez_terms u_terms
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (w_vld),
        .in_w    (w_vec),
        .ops_x   (ops_x),
        .ops_y   (ops_y),
        .out_vld (t_vld),
        .terms_x (terms_x),
        .terms_y (terms_y)
    );

    cbez_sum u_sum
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (t_vld),
        .terms_x (terms_x),
        .terms_y (terms_y),
        .done    (done),
        .pos_x   (pos_x),
        .pos_y   (pos_y),
        .tan_x   (tan_x),
        .tan_y   (tan_y),
        .clipped (clipped)
    );

endmodule
